>>> hw/rtl/gpmd_pkg.sv
// gpmd_pkg: shared types and operation codes for the GF(2) polynomial
// multiply / divide block. No dependencies.

package gpmd_pkg;

   // Width of the operand and result ports
   localparam int DATA_W = 32;

   typedef logic [DATA_W-1:0]   word_type;
   typedef logic [2*DATA_W-1:0] dword_type;

   // Operation codes carried on req_func
   localparam logic FUNC_CLMUL  = 1'b0;
   localparam logic FUNC_DIVMOD = 1'b1;

endpackage : gpmd_pkg

>>> hw/rtl/gf2_poly_mul_divmod.sv
// gf2_poly_mul_divmod: carry-less multiply and polynomial divide over GF(2),
// one set of shift/XOR working registers stepped by a small sequencer.
// Depends on gpmd_pkg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   req     | in        | req_valid / req_ready | func, operand_a, operand_b
//   rsp     | out       | rsp_valid / rsp_ready | result_low, result_high, divide_by_zero
//
// A request runs WIDTH shift/XOR steps in ST_RUN, then ST_FLUSH loads the result
// register; a divide by zero skips the steps. req_ready is high only while idle,
// so a new request is taken only after the last one has loaded its result.
// A result waits in the result register while the next request runs; the next
// finished result holds the sequencer until that register frees.
// Reset is synchronous and clears the sequencer and the result valid flag.

module gf2_poly_mul_divmod
   import gpmd_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_func,
   input  word_type req_operand_a,
   input  word_type req_operand_b,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output word_type rsp_result_low,
   output word_type rsp_result_high,
   output logic     rsp_divide_by_zero
);

   localparam int CNT_W = $clog2(WIDTH);

   // Sequencer state codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             func_ff, func_in;
   logic             dz_ff, dz_in;
   logic [WIDTH-1:0] hi_ff, hi_in;
   logic [WIDTH-1:0] lo_ff, lo_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] hot_ff, hot_in;

   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_low_ff, rsp_low_in;
   word_type         rsp_high_ff, rsp_high_in;
   logic             rsp_dz_ff, rsp_dz_in;

   logic [WIDTH-1:0] a_m, b_m, smear;
   logic [WIDTH-1:0] mul_x, mul_hi, mul_lo;
   logic [WIDTH-1:0] div_t;
   logic             div_q;
   logic [WIDTH-1:0] div_hi, div_lo;
   logic             req_acc, last_step, slot_free;
   dword_type        prod;

   assign a_m       = req_operand_a[WIDTH-1:0];
   assign b_m       = req_operand_b[WIDTH-1:0];
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign last_step = (cnt_ff == CNT_W'(WIDTH - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Leading-one mask of the divisor: smear the bits above each position
   always_comb begin
      smear = b_m >> 1;
      for (int k = 1; k < WIDTH; k = k * 2) begin
         smear = smear | (smear >> k);
      end
      hot_in = b_m & ~smear;
   end

   // Multiply step: add b into the top half when the low bit is set, shift right
   assign mul_x  = hi_ff ^ (lo_ff[0] ? b_ff : '0);
   assign mul_hi = {1'b0, mul_x[WIDTH-1:1]};
   assign mul_lo = {mul_x[0], lo_ff[WIDTH-1:1]};

   // Divide step: bring down the next dividend bit, subtract when degree matches
   // (the remainder stays below the divisor's degree, so its top bit is zero)
   assign div_t  = {hi_ff[WIDTH-2:0], lo_ff[WIDTH-1]};
   assign div_q  = |(div_t & hot_ff);
   assign div_hi = div_q ? (div_t ^ b_ff) : div_t;
   assign div_lo = {lo_ff[WIDTH-2:0], div_q};

   assign prod = dword_type'({hi_ff, lo_ff});

   // Sequencer and working registers
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      func_in  = func_ff;
      dz_in    = dz_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      b_in     = b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               func_in = req_func;
               b_in    = b_m;
               cnt_in  = '0;
               hi_in   = '0;
               if (req_func == FUNC_DIVMOD && b_m == '0) begin
                  dz_in    = 1'b1;
                  lo_in    = '0;
                  state_in = ST_FLUSH;
               end else begin
                  dz_in    = 1'b0;
                  lo_in    = a_m;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (func_ff == FUNC_CLMUL) begin
               hi_in = mul_hi;
               lo_in = mul_lo;
            end else begin
               hi_in = div_hi;
               lo_in = div_lo;
            end
            cnt_in = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_dz_in    = rsp_dz_ff;
      if (state_ff == ST_FLUSH && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_dz_in    = dz_ff;
         if (func_ff == FUNC_CLMUL) begin
            rsp_low_in  = prod[DATA_W-1:0];
            rsp_high_in = prod[2*DATA_W-1:DATA_W];
         end else begin
            rsp_low_in  = word_type'(lo_ff);
            rsp_high_in = word_type'(hi_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      func_ff     <= func_in;
      dz_ff       <= dz_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      b_ff        <= b_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_dz_ff   <= rsp_dz_in;
      if (req_acc) begin
         hot_ff <= hot_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_low     = rsp_low_ff;
   assign rsp_result_high    = rsp_high_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

`ifndef NO_ASSERTIONS
   // Divide-by-zero result carries zero data
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result_low == '0 && rsp_result_high == '0))
      else $error("divide-by-zero result with nonzero data");

   // Divisor mask is one-hot for the whole of a divide
   a_hot_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && func_ff == FUNC_DIVMOD) |-> $onehot(hot_ff))
      else $error("divisor leading-one mask not one-hot");

   // Partial remainder stays below the divisor's degree
   a_rem_degree: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && func_ff == FUNC_DIVMOD && !dz_ff) |-> (hi_ff < hot_ff))
      else $error("remainder degree not below divisor degree");

   // Carry-less product never reaches the top bit of the double word
   a_prod_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && func_ff == FUNC_CLMUL) |-> !hi_ff[WIDTH-1])
      else $error("product top bit set");

   // An accepted request starts work in the next cycle
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_RUN || state_ff == ST_FLUSH))
      else $error("accepted request did not start");
`endif

endmodule : gf2_poly_mul_divmod
